// ===== sv/dfa_rsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// DFA reachable state finder: shared definitions
// Register map codes and item kind codes for the reachable state finder.
// ----------------------------------------------------------------------------
package dfa_rsf_pkg;

   // Width of the APB address: three 32-bit registers at byte addresses 0, 4 and 8.
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Widths fixed by the item and result formats.
   localparam int unsigned STATE_FIELD_W = 5;
   localparam int unsigned SYMBOL_FIELD_W = 3;
   localparam int unsigned COUNT_FIELD_W = 6;
   localparam int unsigned MASK_W = 32;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_START_STATE    = 2'd0,
      REG_STATE_COUNT    = 2'd1,
      REG_ACCEPTING_MASK = 2'd2
   } reg_index_type;

   // Input item kinds.
   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_RUN   = 1'b1
   } kind_type;

endpackage : dfa_rsf_pkg
`default_nettype wire

// ===== sv/dfa_reachable_state_finder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// DFA reachable state finder
// Holds an automaton transition table and finds the states reachable from a
// configured start state, reported as reachable, accepting and non-accepting
// masks.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A write word (kind 0)
// sets or clears one table entry at the accepting edge and gives no result;
// busy stays low, so writes can follow back to back. A run word (kind 1)
// raises busy and starts a search: each cycle in which a state is pending,
// the lowest unexpanded reachable state has its table row read from the row
// memory (one row per state, all symbols side by side, registered read), and
// the row's targets are merged into the reachable set the cycle after. Every
// reachable state is expanded exactly once, but a newly found state can only
// be read once the row that found it has been merged, so the search stalls
// whenever nothing is left to read. Busy falls in the cycle that carries the
// result. The result is shown for one cycle only, marked by rsp_strobe; the
// receiver cannot hold it off. After reset every table entry reads as no
// transition. The user must see that configuration is written through the
// APB port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module dfa_reachable_state_finder_unit #(
   parameter int unsigned NUM_STATES  = 32,
   parameter int unsigned NUM_SYMBOLS = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // Item channel
   input  wire logic                                      start,
   output logic                                           busy,
   input  wire logic                                      req_kind,
   input  wire logic [dfa_rsf_pkg::STATE_FIELD_W-1:0]     req_from_state,
   input  wire logic [dfa_rsf_pkg::SYMBOL_FIELD_W-1:0]    req_symbol,
   input  wire logic [dfa_rsf_pkg::STATE_FIELD_W-1:0]     req_to_state,
   input  wire logic                                      req_to_valid,
   // Result channel
   output logic                                           rsp_strobe,
   output logic [dfa_rsf_pkg::MASK_W-1:0]                 rsp_reachable_mask,
   output logic [dfa_rsf_pkg::MASK_W-1:0]                 rsp_reachable_accepting,
   output logic [dfa_rsf_pkg::MASK_W-1:0]                 rsp_reachable_nonaccepting,
   // Configuration port
   input  wire logic                                      psel,
   input  wire logic                                      penable,
   input  wire logic                                      pwrite,
   input  wire logic [dfa_rsf_pkg::CSR_ADDR_W-1:0]        paddr,
   input  wire logic [dfa_rsf_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [dfa_rsf_pkg::CSR_DATA_W-1:0]             prdata,
   output logic                                           pready
);

   localparam int unsigned ST_W  = $clog2(NUM_STATES);
   localparam int unsigned SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int unsigned TGT_W = dfa_rsf_pkg::STATE_FIELD_W;

   typedef enum logic {
      FSM_IDLE,
      FSM_SEARCH
   } fsm_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [dfa_rsf_pkg::STATE_FIELD_W-1:0] start_state_ff;
   logic [dfa_rsf_pkg::COUNT_FIELD_W-1:0] state_count_ff;
   logic [dfa_rsf_pkg::MASK_W-1:0]        accepting_ff;
   logic                                  csr_write;
   logic [1:0]                            csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         state_count_ff <= dfa_rsf_pkg::COUNT_FIELD_W'(1);
         accepting_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            dfa_rsf_pkg::REG_START_STATE: begin
               start_state_ff <= pwdata[dfa_rsf_pkg::STATE_FIELD_W-1:0];
            end
            dfa_rsf_pkg::REG_STATE_COUNT: begin
               state_count_ff <= pwdata[dfa_rsf_pkg::COUNT_FIELD_W-1:0];
            end
            dfa_rsf_pkg::REG_ACCEPTING_MASK: begin
               accepting_ff <= pwdata[dfa_rsf_pkg::MASK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dfa_rsf_pkg::REG_START_STATE: begin
            prdata = dfa_rsf_pkg::CSR_DATA_W'(start_state_ff);
         end
         dfa_rsf_pkg::REG_STATE_COUNT: begin
            prdata = dfa_rsf_pkg::CSR_DATA_W'(state_count_ff);
         end
         dfa_rsf_pkg::REG_ACCEPTING_MASK: begin
            prdata = dfa_rsf_pkg::CSR_DATA_W'(accepting_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Transition table: targets in a row memory, valid bits in flip-flops
   // so that reset clears every entry at once.
   // ---------------------------------------------------------------------
   logic [NUM_SYMBOLS-1:0][TGT_W-1:0] row_mem [NUM_STATES];
   logic [NUM_STATES-1:0][NUM_SYMBOLS-1:0] entry_valid_ff;

   logic              accept;
   logic              tbl_write;
   logic [ST_W-1:0]   wr_row;
   logic [SYM_W-1:0]  wr_sym;

   assign accept = start & ~busy;
   assign wr_row = ST_W'(req_from_state);
   assign wr_sym = SYM_W'(req_symbol);
   assign tbl_write = accept && (req_kind == dfa_rsf_pkg::KIND_WRITE)
                      && (32'(req_from_state) < NUM_STATES)
                      && (32'(req_symbol) < NUM_SYMBOLS)
                      && !(req_to_valid && (32'(req_to_state) >= NUM_STATES));

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (tbl_write) begin
         entry_valid_ff[wr_row][wr_sym] <= req_to_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_write) begin
         row_mem[wr_row][wr_sym] <= req_to_state;
      end
   end

   // ---------------------------------------------------------------------
   // Search: visited holds every state found so far, pending those whose
   // rows are still to be read.
   // ---------------------------------------------------------------------
   fsm_type                          fsm_ff, fsm_in;
   logic                             busy_ff, busy_in;
   logic [NUM_STATES-1:0]            visited_ff, visited_in;
   logic [NUM_STATES-1:0]            pending_ff, pending_in;
   logic                             inflight_ff, inflight_in;
   logic [NUM_SYMBOLS-1:0][TGT_W-1:0] rd_row_ff;
   logic [NUM_SYMBOLS-1:0]           rd_valid_ff;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic [dfa_rsf_pkg::MASK_W-1:0]   rsp_reach_ff, rsp_acc_ff, rsp_nonacc_ff;

   logic [NUM_STATES-1:0] start_onehot;
   logic [NUM_STATES-1:0] pick_onehot;
   logic [ST_W-1:0]       pick_idx;
   logic                  issue;
   logic [NUM_STATES-1:0] succ;
   logic [NUM_STATES-1:0] in_use;
   logic [NUM_STATES-1:0] reach;
   logic [NUM_STATES-1:0] reach_acc;
   logic                  finish;

   always_comb begin
      for (int i = 0; i < NUM_STATES; i++) begin
         start_onehot[i] = (32'(start_state_ff) == i);
         in_use[i]       = (32'(state_count_ff) > i);
      end
   end

   // Lowest pending state is expanded next.
   assign pick_onehot = pending_ff & (~pending_ff + NUM_STATES'(1));

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
         if (pick_onehot[i]) begin
            pick_idx = pick_idx | ST_W'(i);
         end
      end
   end

   // Targets are checked against the table size when written.
   always_comb begin
      succ = '0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         if (rd_valid_ff[s]) begin
            succ[rd_row_ff[s][ST_W-1:0]] = 1'b1;
         end
      end
   end

   assign issue  = (fsm_ff == FSM_SEARCH) && (pending_ff != '0);
   assign finish = (fsm_ff == FSM_SEARCH) && (pending_ff == '0) && !inflight_ff;

   assign reach     = visited_ff & in_use;
   assign reach_acc = reach & accepting_ff[NUM_STATES-1:0];

   always_comb begin
      fsm_in        = fsm_ff;
      busy_in       = busy_ff;
      visited_in    = visited_ff;
      pending_in    = pending_ff;
      inflight_in   = 1'b0;
      rsp_strobe_in = 1'b0;
      case (fsm_ff)
         FSM_IDLE: begin
            if (accept && (req_kind == dfa_rsf_pkg::KIND_RUN)) begin
               fsm_in     = FSM_SEARCH;
               busy_in    = 1'b1;
               visited_in = start_onehot;
               pending_in = start_onehot;
            end
         end
         FSM_SEARCH: begin
            inflight_in = issue;
            if (issue) begin
               pending_in = pending_ff & ~pick_onehot;
            end
            if (inflight_ff) begin
               // A state just expanded is already visited, so it cannot
               // return to the pending set here.
               visited_in = visited_ff | succ;
               pending_in = pending_in | (succ & ~visited_ff);
            end
            if (finish) begin
               fsm_in        = FSM_IDLE;
               busy_in       = 1'b0;
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            fsm_in  = FSM_IDLE;
            busy_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= FSM_IDLE;
         busy_ff       <= 1'b0;
         visited_ff    <= '0;
         pending_ff    <= '0;
         inflight_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         busy_ff       <= busy_in;
         visited_ff    <= visited_in;
         pending_ff    <= pending_in;
         inflight_ff   <= inflight_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Row read and result registers carry payload only.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_row_ff   <= row_mem[pick_idx];
         rd_valid_ff <= entry_valid_ff[pick_idx];
      end
      if (finish) begin
         rsp_reach_ff  <= dfa_rsf_pkg::MASK_W'(reach);
         rsp_acc_ff    <= dfa_rsf_pkg::MASK_W'(reach_acc);
         rsp_nonacc_ff <= dfa_rsf_pkg::MASK_W'(reach & ~reach_acc);
      end
   end

   assign busy                       = busy_ff;
   assign rsp_strobe                 = rsp_strobe_ff;
   assign rsp_reachable_mask         = rsp_reach_ff;
   assign rsp_reachable_accepting    = rsp_acc_ff;
   assign rsp_reachable_nonaccepting = rsp_nonacc_ff;

endmodule : dfa_reachable_state_finder_unit
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the DFA reachable state finder
// Drives table writes and search runs through the start/busy channel,
// configures the start state, state count and accepting mask over APB, and
// checks every result strobe against a local predictor of the reachable sets.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_STATES  = 32;
   localparam int unsigned NUM_SYMBOLS = 8;
   localparam int unsigned ST_FW  = dfa_rsf_pkg::STATE_FIELD_W;
   localparam int unsigned SYM_FW = dfa_rsf_pkg::SYMBOL_FIELD_W;
   localparam int unsigned CNT_FW = dfa_rsf_pkg::COUNT_FIELD_W;
   localparam int unsigned MSK_W  = dfa_rsf_pkg::MASK_W;
   localparam int unsigned DATA_W = dfa_rsf_pkg::CSR_DATA_W;
   // Address slot beyond the register list; writes there must change nothing.
   localparam logic [1:0] REG_UNLISTED = 2'd3;

   typedef struct packed {
      logic             defined;
      logic [ST_FW-1:0] target;
   } arc_type;

   typedef struct packed {
      logic [MSK_W-1:0] reachable;
      logic [MSK_W-1:0] accepting;
      logic [MSK_W-1:0] nonaccepting;
   } reach_masks_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   wire logic                 busy;
   logic                      req_kind = dfa_rsf_pkg::KIND_WRITE;
   logic [ST_FW-1:0]          req_from_state = '0;
   logic [SYM_FW-1:0]         req_symbol = '0;
   logic [ST_FW-1:0]          req_to_state = '0;
   logic                      req_to_valid = 1'b0;
   wire logic                 rsp_strobe;
   wire logic [MSK_W-1:0]     rsp_reachable_mask;
   wire logic [MSK_W-1:0]     rsp_reachable_accepting;
   wire logic [MSK_W-1:0]     rsp_reachable_nonaccepting;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [dfa_rsf_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0]         pwdata = '0;
   wire logic [DATA_W-1:0]    prdata;
   wire logic                 pready;

   // Predictor state: its own copy of the table and the registers.
   arc_type                   arc_table [NUM_STATES][NUM_SYMBOLS];
   logic [ST_FW-1:0]          cfg_start;
   logic [CNT_FW-1:0]         cfg_count;
   logic [MSK_W-1:0]          cfg_accepting;

   reach_masks_type           pending_masks [$];
   int unsigned               words_taken = 0;
   int unsigned               mismatch_count = 0;
   int unsigned               sender_idle_pct = 0;
   logic [ST_FW-1:0]          chosen_start = '0;

   dfa_reachable_state_finder_unit #(
      .NUM_STATES (NUM_STATES),
      .NUM_SYMBOLS(NUM_SYMBOLS)
   ) u_top (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_kind                  (req_kind),
      .req_from_state            (req_from_state),
      .req_symbol                (req_symbol),
      .req_to_state              (req_to_state),
      .req_to_valid              (req_to_valid),
      .rsp_strobe                (rsp_strobe),
      .rsp_reachable_mask        (rsp_reachable_mask),
      .rsp_reachable_accepting   (rsp_reachable_accepting),
      .rsp_reachable_nonaccepting(rsp_reachable_nonaccepting),
      .psel                      (psel),
      .penable                   (penable),
      .pwrite                    (pwrite),
      .paddr                     (paddr),
      .pwdata                    (pwdata),
      .prdata                    (prdata),
      .pready                    (pready)
   );

   always #5ns clock = ~clock;

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // Frontier sweeps from the start state until a sweep adds nothing new.
   function automatic reach_masks_type find_reachable();
      logic [MSK_W-1:0] visited;
      logic [MSK_W-1:0] frontier;
      logic [MSK_W-1:0] next_set;
      logic [MSK_W-1:0] in_use;
      int unsigned      n;
      reach_masks_type  r;
      visited  = 32'd1 << cfg_start;
      frontier = visited;
      while (frontier != '0) begin
         next_set = '0;
         for (int s = 0; s < NUM_STATES; s++) begin
            if (frontier[s]) begin
               for (int a = 0; a < NUM_SYMBOLS; a++) begin
                  if (arc_table[s][a].defined) begin
                     next_set[arc_table[s][a].target] = 1'b1;
                  end
               end
            end
         end
         frontier = next_set & ~visited;
         visited  = visited | frontier;
      end
      // A count above the table saturates; zero leaves no state in use.
      n = (cfg_count > NUM_STATES) ? NUM_STATES : cfg_count;
      in_use = 32'((64'd1 << n) - 64'd1);
      r.reachable    = visited & in_use;
      r.accepting    = r.reachable & cfg_accepting;
      r.nonaccepting = r.reachable & ~cfg_accepting;
      return r;
   endfunction

   function automatic void check_field(string name, logic [MSK_W-1:0] want,
                                       logic [MSK_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : observe
      reach_masks_type want;
      if (reset) begin
         foreach (arc_table[s, a]) arc_table[s][a] = '0;
         cfg_start     = '0;
         cfg_count     = 6'd1;
         cfg_accepting = '0;
      end else begin
         if (rsp_strobe) begin
            if (pending_masks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result word with no search outstanding", $realtime);
               end
            end else begin
               want = pending_masks.pop_front();
               check_field("reachable_mask", want.reachable, rsp_reachable_mask);
               check_field("reachable_accepting", want.accepting, rsp_reachable_accepting);
               check_field("reachable_nonaccepting", want.nonaccepting,
                           rsp_reachable_nonaccepting);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               dfa_rsf_pkg::REG_START_STATE:    cfg_start = pwdata[ST_FW-1:0];
               dfa_rsf_pkg::REG_STATE_COUNT:    cfg_count = pwdata[CNT_FW-1:0];
               dfa_rsf_pkg::REG_ACCEPTING_MASK: cfg_accepting = pwdata[MSK_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            words_taken++;
            if (req_kind == dfa_rsf_pkg::KIND_RUN) begin
               pending_masks.push_back(find_reachable());
            end else if (req_to_valid) begin
               arc_table[req_from_state][req_symbol] = '{1'b1, req_to_state};
            end else begin
               arc_table[req_from_state][req_symbol] = '0;
            end
         end
      end
   end

   // Presents one word, after a random gap, and returns at the falling edge
   // that follows its acceptance.
   task automatic send_word(dfa_rsf_pkg::kind_type kind, logic [ST_FW-1:0] from_s,
                            logic [SYM_FW-1:0] sym,
                            logic [ST_FW-1:0] to_s, logic to_v);
      int unsigned gap;
      int unsigned taken_before;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < 60) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_from_state <= from_s;
      req_symbol     <= sym;
      req_to_state   <= to_s;
      req_to_valid   <= to_v;
      taken_before = words_taken;
      do @(negedge clock); while (words_taken == taken_before);
   endtask

   task automatic write_entry(logic [ST_FW-1:0] from_s,
                              logic [SYM_FW-1:0] sym,
                              logic [ST_FW-1:0] to_s, logic to_v);
      send_word(dfa_rsf_pkg::KIND_WRITE, from_s, sym, to_s, to_v);
   endtask

   // The entry fields are don't-care on a run, so they carry noise.
   task automatic run_search();
      send_word(dfa_rsf_pkg::KIND_RUN, 5'($urandom), 3'($urandom), 5'($urandom),
                1'($urandom));
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_masks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apb_write(logic [1:0] index, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(logic [ST_FW-1:0] st, logic [CNT_FW-1:0] cnt,
                             logic [MSK_W-1:0] acc);
      settle();
      apb_write(dfa_rsf_pkg::REG_START_STATE, 32'(st));
      apb_write(dfa_rsf_pkg::REG_STATE_COUNT, 32'(cnt));
      apb_write(dfa_rsf_pkg::REG_ACCEPTING_MASK, acc);
      chosen_start = st;
   endtask

   task automatic test_reset_defaults();
      // Empty table, start 0, one state in use, nothing accepting.
      run_search();
   endtask

   task automatic test_entry_write_and_clear();
      set_config(5'd0, 6'd32, 32'h8000_0001);
      write_entry(5'd0, 3'd0, 5'd31, 1'b1);
      write_entry(5'd31, 3'd7, 5'd0, 1'b1);
      run_search();
      // Clearing ignores the target field.
      write_entry(5'd0, 3'd0, 5'd31, 1'b0);
      run_search();
      write_entry(5'd0, 3'd0, 5'd5, 1'b1);
      write_entry(5'd0, 3'd0, 5'd9, 1'b1);
      run_search();
      set_config(5'd9, 6'd32, 32'h0000_0200);
      write_entry(5'd9, 3'd3, 5'd9, 1'b1);
      run_search();
   endtask

   task automatic test_state_count_limits();
      set_config(5'd0, 6'd0, '1);
      run_search();
      set_config(5'd0, 6'd63, '1);
      run_search();
      set_config(5'd0, 6'd33, 32'h5555_5555);
      run_search();
   endtask

   task automatic test_unused_states();
      // State 20 is outside the four in use but still carries the search on.
      set_config(5'd0, 6'd4, 32'hFFFF_FFF4);
      write_entry(5'd0, 3'd1, 5'd20, 1'b1);
      write_entry(5'd20, 3'd2, 5'd2, 1'b1);
      run_search();
   endtask

   task automatic test_unlisted_register();
      set_config(5'd31, 6'd32, 32'hAAAA_AAAA);
      apb_write(REG_UNLISTED, '1);
      run_search();
   endtask

   task automatic random_setting();
      logic [CNT_FW-1:0] cnt;
      logic [MSK_W-1:0]  acc;
      case ($urandom_range(9))
         0:       cnt = 6'd0;
         1:       cnt = 6'd32;
         2:       cnt = 6'($urandom_range(33, 63));
         3:       cnt = 6'd1;
         default: cnt = 6'($urandom_range(1, 32));
      endcase
      case ($urandom_range(5))
         0:       acc = '0;
         1:       acc = '1;
         default: acc = $urandom;
      endcase
      set_config(5'($urandom_range(31)), cnt, acc);
   endtask

   // Most entries land on symbols 0 and 1, and most scattered entries are clears,
   // which keeps the graph sparse enough for searches to stop short.
   task automatic random_episode(inout int unsigned sent);
      logic [NUM_STATES-1:0] used;
      logic [ST_FW-1:0]      cur;
      logic [ST_FW-1:0]      nxt;
      logic [SYM_FW-1:0]     sym;
      logic                  valid;
      int unsigned           len;
      if ($urandom_range(3) == 0) begin
         // A chain of distinct states from the start makes a deep search.
         len  = ($urandom_range(9) == 0) ? $urandom_range(10, 31) : $urandom_range(1, 6);
         cur  = chosen_start;
         used = '0;
         used[cur] = 1'b1;
         repeat (len) begin
            do nxt = 5'($urandom_range(31)); while (used[nxt]);
            used[nxt] = 1'b1;
            sym = ($urandom_range(9) != 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
            write_entry(cur, sym, nxt, 1'b1);
            cur = nxt;
            sent++;
         end
      end else begin
         repeat ($urandom_range(0, 8)) begin
            valid = ($urandom_range(9) == 0);
            sym = ($urandom_range(3) != 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
            write_entry(5'($urandom), sym, 5'($urandom), valid);
            sent++;
         end
      end
      run_search();
      sent++;
   endtask

   task automatic test_random_traffic(int unsigned idle_pct, int unsigned word_total);
      int unsigned sent;
      int unsigned block_end;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < word_total) begin
         random_setting();
         block_end = sent + 40;
         while (sent < block_end) random_episode(sent);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_entry_write_and_clear();
      test_state_count_limits();
      test_unused_states();
      test_unlisted_register();
      test_random_traffic(32, 640);
      test_random_traffic(51, 640);
      test_random_traffic(0, 640);
      settle();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && pending_masks.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : tb_top
`default_nettype wire

// ===== dfa_reachable_state_finder_unit.f =====
sv/dfa_rsf_pkg.sv
sv/dfa_reachable_state_finder_unit.sv
sim/tb_top.sv
